@@ src/multi_channel_watchdog_table_defines.svh @@
// ----------------------------------------------------------------------------
// multi_channel_watchdog_table_defines
// assertion macros shared by the watchdog table
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WATCHDOG_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_WATCHDOG_TABLE_DEFINES_SVH

// same-cycle implication
`define MCWT_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("watchdog table assertion failed");

// next-cycle implication
`define MCWT_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("watchdog table assertion failed");

`endif

@@ src/mcwt_pkg.sv @@
// ----------------------------------------------------------------------------
// mcwt_pkg
// types and constants of the multi-channel watchdog table
// ----------------------------------------------------------------------------
package mcwt_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_FEED     = 2'd1,
        OP_CHECK    = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] timeout;
        logic [31:0] last_feed;
        logic        healthy;
        logic [15:0] restarts;
    } entry_t;

    typedef struct packed {
        logic        id_match;
        logic        expired;
        logic [15:0] restarts_inc;
    } cmp_t;

endpackage

@@ src/mcwt_entry_table.sv @@
// ----------------------------------------------------------------------------
// mcwt_entry_table
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module mcwt_entry_table
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
)
(
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mcwt_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// mcwt_cmp_unit
// shared compare unit: id match, elapsed-time expiry, restart increment
// ----------------------------------------------------------------------------
module mcwt_cmp_unit
(
    input  mcwt_pkg::entry_t entry,
    input  logic [31:0]      client_id,
    input  logic [31:0]      now_ms,
    output mcwt_pkg::cmp_t   result
);

    logic [31:0] elapsed;

    always_comb
    begin
        elapsed             = now_ms - entry.last_feed;
        result.id_match     = (entry.id == client_id);
        result.expired      = (entry.timeout != 32'd0) && (elapsed > entry.timeout);
        result.restarts_inc = (entry.restarts == 16'hFFFF) ? entry.restarts
                                                          : entry.restarts + 16'd1;
    end

endmodule

@@ src/mcwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcwt_ctrl
// sequencer: walks the table one slot a cycle and holds the result
// ----------------------------------------------------------------------------
module mcwt_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [95:0]                s_axis_tdata,
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [39:0]                m_axis_tdata,
    output logic                       wr_en,
    output logic [mcwt_pkg::IDX_W-1:0] wr_idx,
    output mcwt_pkg::entry_t           wr_data,
    output logic [mcwt_pkg::IDX_W-1:0] rd_idx,
    input  mcwt_pkg::entry_t           rd_data,
    output logic [31:0]                cmp_id,
    output logic [31:0]                cmp_now,
    input  mcwt_pkg::cmp_t             cmp
);

    mcwt_pkg::state_t state_reg, state_next;
    mcwt_pkg::op_t    op_reg, op_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] tmo_reg, tmo_next;
    logic [31:0] now_reg, now_next;
    logic [mcwt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [mcwt_pkg::CNT_W-1:0] scan_reg, scan_next;
    logic [1:0]  status_reg, status_next;
    logic        healthy_reg, healthy_next;
    logic [15:0] restarts_reg, restarts_next;
    logic [7:0]  mask_reg, mask_next;
    logic [3:0]  xcount_reg, xcount_next;
    logic [2:0]  index_reg, index_next;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        in_accept;
    logic        in_range;
    logic        out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = (scan_reg < count_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    // read one slot ahead so the registered read lines up with scan_reg
    assign rd_idx    = scan_next[mcwt_pkg::IDX_W-1:0];
    assign cmp_id    = id_reg;
    assign cmp_now   = now_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcwt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = mcwt_pkg::ST_SCAN;
                end
            end
            mcwt_pkg::ST_SCAN:
            begin
                unique case (op_reg)
                    mcwt_pkg::OP_REGISTER:
                    begin
                        state_next = mcwt_pkg::ST_DONE;
                    end
                    mcwt_pkg::OP_CHECK:
                    begin
                        if (!in_range)
                        begin
                            state_next = mcwt_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (!in_range || cmp.id_match)
                        begin
                            state_next = mcwt_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            mcwt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mcwt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcwt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_axis_tready  = (state_reg == mcwt_pkg::ST_IDLE);
        m_axis_tvalid  = out_valid_reg;
        m_axis_tdata   = out_data_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        tmo_next       = tmo_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        status_next    = status_reg;
        healthy_next   = healthy_reg;
        restarts_next  = restarts_reg;
        mask_next      = mask_reg;
        xcount_next    = xcount_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_idx         = scan_reg[mcwt_pkg::IDX_W-1:0];
        wr_data        = rd_data;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mcwt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = mcwt_pkg::op_t'(s_axis_tuser);
                    id_next       = s_axis_tdata[31:0];
                    tmo_next      = s_axis_tdata[63:32];
                    now_next      = s_axis_tdata[95:64];
                    scan_next     = '0;
                    status_next   = mcwt_pkg::STATUS_OK;
                    healthy_next  = 1'b0;
                    restarts_next = 16'd0;
                    mask_next     = 8'd0;
                    xcount_next   = 4'd0;
                    index_next    = 3'd0;
                end
            end
            mcwt_pkg::ST_SCAN:
            begin
                unique case (op_reg)
                    mcwt_pkg::OP_REGISTER:
                    begin
                        if (count_reg >= mcwt_pkg::CNT_W'(mcwt_pkg::ENTRIES))
                        begin
                            status_next = mcwt_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_idx            = count_reg[mcwt_pkg::IDX_W-1:0];
                            wr_data.id        = id_reg;
                            wr_data.timeout   = tmo_reg;
                            wr_data.last_feed = now_reg;
                            wr_data.healthy   = 1'b1;
                            wr_data.restarts  = 16'd0;
                            index_next        = 3'(count_reg);
                            count_next        = count_reg + 1'b1;
                        end
                    end
                    mcwt_pkg::OP_CHECK:
                    begin
                        if (in_range)
                        begin
                            scan_next = scan_reg + 1'b1;
                            if (cmp.expired)
                            begin
                                wr_en             = 1'b1;
                                wr_data.healthy   = 1'b0;
                                wr_data.restarts  = cmp.restarts_inc;
                                wr_data.last_feed = now_reg;
                                if (32'(scan_reg) < 32'd8)
                                begin
                                    mask_next = mask_reg | (8'd1 << scan_reg);
                                end
                                if (xcount_reg != 4'hF)
                                begin
                                    xcount_next = xcount_reg + 4'd1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (!in_range)
                        begin
                            status_next = mcwt_pkg::STATUS_NOT_FOUND;
                        end
                        else if (cmp.id_match)
                        begin
                            index_next = 3'(scan_reg);
                            if (op_reg == mcwt_pkg::OP_FEED)
                            begin
                                wr_en             = 1'b1;
                                wr_data.last_feed = now_reg;
                                wr_data.healthy   = 1'b1;
                            end
                            else
                            begin
                                healthy_next  = rd_data.healthy;
                                restarts_next = rd_data.restarts;
                            end
                        end
                        else
                        begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                endcase
            end
            mcwt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, index_reg, xcount_reg, mask_reg,
                                      restarts_reg, healthy_reg, status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcwt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        tmo_reg      <= tmo_next;
        now_reg      <= now_next;
        scan_reg     <= scan_next;
        status_reg   <= status_next;
        healthy_reg  <= healthy_next;
        restarts_reg <= restarts_next;
        mask_reg     <= mask_next;
        xcount_reg   <= xcount_next;
        index_reg    <= index_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/multi_channel_watchdog_table.sv @@
// ----------------------------------------------------------------------------
// multi_channel_watchdog_table
// table of per-client watchdogs: register, feed, check and query
// register writes its slot directly; feed, query and check scan the slots in use one slot a cycle
// a new transaction is accepted only once the previous one has finished its scan
// the next transaction is taken while a finished result waits in the output register
// reset clears the entry count and the handshake state; slot contents are left as they are
// ----------------------------------------------------------------------------
`include "multi_channel_watchdog_table_defines.svh"

module multi_channel_watchdog_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // client_id, timeout_ms, now_ms
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, healthy, restart_count, expired_mask,
                                        // expired_count, entry_index, zero pad
);

    logic                       wr_en;
    logic [mcwt_pkg::IDX_W-1:0] wr_idx;
    mcwt_pkg::entry_t           wr_data;
    logic [mcwt_pkg::IDX_W-1:0] rd_idx;
    mcwt_pkg::entry_t           rd_data;
    logic [31:0]                cmp_id;
    logic [31:0]                cmp_now;
    mcwt_pkg::cmp_t             cmp;
    logic                       in_hs;
    logic                       rsp_error;
    logic                       mask_checkable;
    logic [27:0]                rsp_payload;
    logic [7:0]                 rsp_mask;
    logic [3:0]                 rsp_xcount;
    logic [2:0]                 rsp_index;

    mcwt_entry_table
    #(
        .WIDTH ($bits(mcwt_pkg::entry_t)),
        .DEPTH (mcwt_pkg::ENTRIES)
    )
    u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_data),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    mcwt_cmp_unit u_cmp
    (
        .entry     (rd_data),
        .client_id (cmp_id),
        .now_ms    (cmp_now),
        .result    (cmp)
    );

    mcwt_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_idx        (wr_idx),
        .wr_data       (wr_data),
        .rd_idx        (rd_idx),
        .rd_data       (rd_data),
        .cmp_id        (cmp_id),
        .cmp_now       (cmp_now),
        .cmp           (cmp)
    );

    assign in_hs          = s_axis_tvalid && s_axis_tready;
    assign rsp_error      = m_axis_tvalid && (m_axis_tdata[1:0] != mcwt_pkg::STATUS_OK);
    assign mask_checkable = m_axis_tvalid && (mcwt_pkg::ENTRIES <= 8);
    assign rsp_payload    = m_axis_tdata[30:3];
    assign rsp_mask       = m_axis_tdata[26:19];
    assign rsp_xcount     = m_axis_tdata[30:27];
    assign rsp_index      = m_axis_tdata[33:31];

    `MCWT_ASSERT_NEXT(a_busy_after_accept, in_hs, !s_axis_tready)
    `MCWT_ASSERT_NOW(a_error_no_payload, rsp_error, (rsp_payload == 28'd0) && (rsp_index == 3'd0))
    `MCWT_ASSERT_NOW(a_mask_count, mask_checkable, $countones(rsp_mask) == 32'(rsp_xcount))

endmodule
